@@ design/pvd_pkg.sv @@
`default_nettype none

package pvd_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_OVER  = 2'd2
  } pvd_status_e;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned LenW    = 4;
  localparam logic [LenW-1:0] MaxLen = 4'd9;

  // raw nine-byte payloads at or above this wrap past 2^64-1 once offset
  localparam logic [ValueW-1:0] OverflowLimit = 64'hFEFD_FBF7_EFDF_BF80;

  // one decode result as it leaves the step logic
  typedef struct packed {
    logic                valid;
    logic [ValueW-1:0]   value;
    logic [LenW-1:0]     length;
    pvd_status_e         status;
  } pvd_result_t;

  // leading ones of the first byte plus one, 1 to 9
  function automatic logic [LenW-1:0] prefix_len(input logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    logic            run;
    n   = 4'd1;
    run = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      run = run & b[i];
      if (run) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

  // offset that makes every length cover its own value range
  function automatic logic [ValueW-1:0] len_offset(input logic [LenW-1:0] len);
    logic [ValueW-1:0] off;
    unique case (len)
      4'd2:    off = 64'h0000_0000_0000_0080;
      4'd3:    off = 64'h0000_0000_0000_4080;
      4'd4:    off = 64'h0000_0000_0020_4080;
      4'd5:    off = 64'h0000_0000_1020_4080;
      4'd6:    off = 64'h0000_0008_1020_4080;
      4'd7:    off = 64'h0000_0408_1020_4080;
      4'd8:    off = 64'h0002_0408_1020_4080;
      4'd9:    off = 64'h0102_0408_1020_4080;
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

@@ design/pvd_step.sv @@
`default_nettype none

module pvd_step import pvd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [ByteW-1:0]  data_byte_i,
  input  wire logic              end_of_data_i,
  output pvd_result_t            res_o
);

  logic [LenW-1:0]   exp_len_q, exp_len_d;
  logic [LenW-1:0]   seen_q, seen_d;
  logic [ValueW-1:0] acc_q, acc_d;

  logic              first;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   seen_nxt;
  logic [ValueW-1:0] acc_nxt;
  logic              done;
  logic              trunc;
  logic              over;
  logic [ByteW-1:0]  head_bits;

  // first byte of a code sets the length, later bytes shift in big-endian
  always_comb begin
    first     = (exp_len_q == '0) || (exp_len_q > MaxLen);
    len       = first ? prefix_len(data_byte_i) : exp_len_q;
    head_bits = data_byte_i & (8'hFF >> len);
    seen_nxt  = first ? 4'd1 : seen_q + 4'd1;
    acc_nxt   = first ? {{(ValueW-ByteW){1'b0}}, head_bits}
                      : {acc_q[ValueW-ByteW-1:0], data_byte_i};
    done      = (seen_nxt >= len);
    trunc     = !done && end_of_data_i;
    over      = done && (len == MaxLen) && (acc_nxt >= OverflowLimit);
  end

  // result of this byte
  always_comb begin
    res_o.valid  = done || trunc;
    res_o.value  = '0;
    res_o.length = '0;
    res_o.status = ST_OK;
    if (trunc) begin
      res_o.status = ST_TRUNC;
    end else if (over) begin
      res_o.status = ST_OVER;
    end else begin
      res_o.value  = acc_nxt + len_offset(len);
      res_o.length = len;
    end
  end

  // code state, back to idle on any result
  always_comb begin
    exp_len_d = exp_len_q;
    seen_d    = seen_q;
    acc_d     = acc_q;
    if (en_i) begin
      if (done || trunc) begin
        exp_len_d = '0;
        seen_d    = '0;
        acc_d     = '0;
      end else begin
        exp_len_d = len;
        seen_d    = seen_nxt;
        acc_d     = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      seen_q    <= '0;
      acc_q     <= '0;
    end else begin
      exp_len_q <= exp_len_d;
      seen_q    <= seen_d;
      acc_q     <= acc_d;
    end
  end

endmodule

`default_nettype wire

@@ design/prefix_varint_decoder.sv @@
`default_nettype none

// Prefix-length varint decoder: takes one byte of an encoded stream per
// request and returns one result per completed code (value, length, ok),
// per code cut short by end_of_data (truncated, zeros) or per nine-byte
// code whose value would pass 2^64-1 (overflow, zeros). Bytes that neither
// complete a code nor end the data give no result. A new byte is taken every
// cycle while the output side keeps up; a byte's result goes from the input
// register through the decode step with its 64-bit offset add into the result
// register. A stall on the output holds the result and, one byte later,
// stalls the input.

module prefix_varint_decoder import pvd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [ByteW-1:0]  data_byte_i,
  input  wire logic              end_of_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [ValueW-1:0] decoded_value_o,
  output      logic [LenW-1:0]   code_length_o,
  output      logic [1:0]        status_o
);

  logic              in_valid_q, in_valid_d;
  logic [ByteW-1:0]  byte_q;
  logic              eod_q;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] value_q;
  logic [LenW-1:0]   len_q;
  pvd_status_e       status_q;

  logic              out_free;
  logic              proceed;
  logic              accept;
  pvd_result_t       res;

  // handshake
  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    proceed     = in_valid_q && out_free;
    in_stall_o  = in_valid_q && !out_free;
    accept      = in_valid_i && !in_stall_o;
    in_valid_d  = accept || (in_valid_q && !proceed);
    out_valid_d = out_free ? (proceed && res.valid) : out_valid_q;
  end

  // decode step on the registered byte
  pvd_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (proceed),
    .data_byte_i   (byte_q),
    .end_of_data_i (eod_q),
    .res_o         (res)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input request register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      eod_q  <= end_of_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (proceed && res.valid) begin
      value_q  <= res.value;
      len_q    <= res.length;
      status_q <= res.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_value_o = value_q;
  assign code_length_o   = len_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

@@ design/pvd_checker.sv @@
`default_nettype none

module pvd_sva import pvd_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [ValueW-1:0] decoded_value_o,
  input wire logic [LenW-1:0]   code_length_o,
  input wire logic [1:0]        status_o
);

  // only the three defined status codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_TRUNC || status_o == ST_OVER))
    else $error("undefined status code");

  // error results carry zero value and zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (decoded_value_o == '0 && code_length_o == '0))
    else $error("error result with nonzero payload");

  // ok results carry a length of one to nine bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |-> (code_length_o != '0 && code_length_o <= MaxLen))
    else $error("ok result with bad length");

  // a stalled result stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(decoded_value_o) && $stable(code_length_o) && $stable(status_o)))
    else $error("stalled result changed");

  // input stalls only while a byte waits behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

endmodule

bind prefix_varint_decoder pvd_sva u_pvd_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .decoded_value_o (decoded_value_o),
  .code_length_o   (code_length_o),
  .status_o        (status_o)
);

`default_nettype wire

@@ sim/pvd_checker.sv @@
`timescale 1ns / 100ps

module pvd_checker import pvd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              end_of_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ValueW-1:0] decoded_value_i,
  input  logic [LenW-1:0]   code_length_i,
  input  logic [1:0]        status_i,
  output int                fail_count_o,
  output int                outstanding_o,
  output int                bytes_taken_o,
  output int                ok_count_o,
  output int                trunc_count_o,
  output int                over_count_o,
  output logic [9:0]        lengths_seen_o
);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   length;
    pvd_status_e       status;
  } decode_t;

  // decodes still owed by the block, oldest first
  decode_t decode_q[$];
  decode_t want;

  // shadow of the code in progress
  logic [LenW-1:0]   cur_len;
  logic [LenW-1:0]   cur_count;
  logic [ValueW-1:0] cur_raw;

  int         errors;
  int         taken;
  int         n_ok;
  int         n_trunc;
  int         n_over;
  logic [9:0] len_mask;

  // one plus the run of leading ones
  function automatic logic [LenW-1:0] lead_ones_len(input logic [ByteW-1:0] b);
    int n;
    n = 1;
    while (n <= 8 && b[8-n]) begin
      n++;
    end
    return LenW'(n);
  endfunction

  // smallest value carried by a code of this length: sum of 2^(7k)
  function automatic logic [ValueW-1:0] base_of(input logic [LenW-1:0] len);
    logic [ValueW-1:0] base;
    base = '0;
    for (int k = 1; k < int'(len); k++) begin
      base += 64'd1 << (7 * k);
    end
    return base;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic go_idle();
    cur_len   = '0;
    cur_count = '0;
    cur_raw   = '0;
  endtask

  // advance the shadow decoder by one byte, queue any result it owes
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic last);
    logic [LenW-1:0]   len;
    logic [ValueW-1:0] raw;
    decode_t           res;
    if (cur_len == '0 || cur_len > MaxLen) begin
      len       = lead_ones_len(b);
      cur_len   = len;
      cur_count = 4'd1;
      cur_raw   = (len <= 4'd8) ? ValueW'(b & (8'hFF >> len)) : '0;
    end else begin
      len       = cur_len;
      cur_raw   = {cur_raw[ValueW-9:0], b};
      cur_count = cur_count + 4'd1;
    end
    if (cur_count >= len) begin
      raw = cur_raw;
      go_idle();
      if (len == MaxLen && raw >= OverflowLimit) begin
        res = '{value: '0, length: '0, status: ST_OVER};
      end else begin
        res = '{value: raw + base_of(len), length: len, status: ST_OK};
      end
      decode_q.push_back(res);
    end else if (last) begin
      go_idle();
      res = '{value: '0, length: '0, status: ST_TRUNC};
      decode_q.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_idle();
      decode_q.delete();
      errors   = 0;
      taken    = 0;
      n_ok     = 0;
      n_trunc  = 0;
      n_over   = 0;
      len_mask = '0;
    end else begin
      // compare a delivered result against the oldest owed one
      if (out_valid_i && !out_stall_i) begin
        if (decode_q.size() == 0) begin
          report_error($sformatf("unexpected result value %h length %0d status %0d",
                                 decoded_value_i, code_length_i, status_i));
        end else begin
          want = decode_q.pop_front();
          if (decoded_value_i !== want.value) begin
            report_error($sformatf("value %h, predicted %h", decoded_value_i, want.value));
          end
          if (code_length_i !== want.length) begin
            report_error($sformatf("length %0d, predicted %0d", code_length_i, want.length));
          end
          if (status_i !== want.status) begin
            report_error($sformatf("status %0d, predicted %s", status_i, want.status.name()));
          end
          case (want.status)
            ST_OK: begin
              n_ok++;
              len_mask[want.length] = 1'b1;
            end
            ST_TRUNC: n_trunc++;
            default:  n_over++;
          endcase
        end
      end
      // predict from an accepted byte
      if (in_valid_i && !in_stall_i) begin
        taken++;
        decode_byte(data_byte_i, end_of_data_i);
      end
    end
    fail_count_o   <= errors;
    outstanding_o  <= decode_q.size();
    bytes_taken_o  <= taken;
    ok_count_o     <= n_ok;
    trunc_count_o  <= n_trunc;
    over_count_o   <= n_over;
    lengths_seen_o <= len_mask;
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pvd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int StreamBytes = 1125;
  localparam int HoldAfter   = 400;
  localparam int HoldCycles  = 300;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PULSED
  } stall_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  logic              byte_valid;
  logic              byte_stall;
  logic [ByteW-1:0]  byte_data;
  logic              byte_last;
  logic              res_valid;
  logic              res_stall;
  logic [ValueW-1:0] res_value;
  logic [LenW-1:0]   res_length;
  logic [1:0]        res_status;

  int         fail_count;
  int         outstanding;
  int         bytes_taken;
  int         ok_count;
  int         trunc_count;
  int         over_count;
  logic [9:0] lengths_seen;

  int   cycles     = 0;
  int   burst_left = 0;
  int   bytes_sent = 0;
  logic held       = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  prefix_varint_decoder uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (byte_valid),
    .in_stall_o      (byte_stall),
    .data_byte_i     (byte_data),
    .end_of_data_i   (byte_last),
    .out_valid_o     (res_valid),
    .out_stall_i     (res_stall),
    .decoded_value_o (res_value),
    .code_length_o   (res_length),
    .status_o        (res_status)
  );

  pvd_checker chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (byte_valid),
    .in_stall_i      (byte_stall),
    .data_byte_i     (byte_data),
    .end_of_data_i   (byte_last),
    .out_valid_i     (res_valid),
    .out_stall_i     (res_stall),
    .decoded_value_i (res_value),
    .code_length_i   (res_length),
    .status_i        (res_status),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .bytes_taken_o   (bytes_taken),
    .ok_count_o      (ok_count),
    .trunc_count_o   (trunc_count),
    .over_count_o    (over_count),
    .lengths_seen_o  (lengths_seen)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  // result side stalls in runs of varying density, plus one long hold-off
  initial begin
    stall_mode_e mode;
    int          run;
    res_stall <= 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      run  = $urandom_range(8, 120);
      for (int k = 0; k < run; k++) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  res_stall <= 1'b0;
          STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: res_stall <= ($urandom_range(0, 1) == 1);
          default:     res_stall <= ((k / 5) % 2 == 1);
        endcase
      end
      // hold the output long enough to back the block up into its input
      if (!held && bytes_taken >= HoldAfter) begin
        held = 1'b1;
        for (int k = 0; k < HoldCycles; k++) begin
          @(posedge clk);
          res_stall <= 1'b1;
        end
      end
    end
  end

  // offer one byte, opening a new burst after a random gap when due
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_data  <= b;
    byte_last  <= last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // encode a payload as a code of the given length; a nonzero cut below len
  // sends only that many bytes with end_of_data on the last, otherwise end_flag
  // rides on the final byte
  task automatic send_code(input int len, input logic [ValueW-1:0] raw,
                           input int cut, input logic end_flag);
    logic [ByteW-1:0] first;
    int               count;
    if (len == 9) begin
      first = 8'hFF;
    end else begin
      first = ~(8'hFF >> (len - 1)) | (8'(raw >> (8 * (len - 1))) & (8'hFF >> len));
    end
    count = (cut > 0 && cut < len) ? cut : len;
    for (int i = 0; i < count; i++) begin
      send_byte((i == 0) ? first : raw[8 * (len - 1 - i) +: 8],
                (i == count - 1) ? ((count < len) || end_flag) : 1'b0);
    end
  endtask

  initial begin
    int                len;
    int                cut;
    logic [ValueW-1:0] raw;
    byte_valid <= 1'b0;
    byte_data  <= '0;
    byte_last  <= 1'b0;
    rst_n      <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: length extremes, end flag on a completing byte, truncation
    // on the first and on a later byte, largest value and nine-byte overflow
    send_code(1, 64'h0, 0, 1'b1);
    send_code(1, 64'h7F, 0, 1'b0);
    send_code(2, 64'h0, 0, 1'b0);
    send_code(2, 64'h3FFF, 0, 1'b1);
    send_code(4, 64'h1F_FFFF, 1, 1'b0);
    send_code(3, 64'h1A_5A5A, 2, 1'b0);
    send_code(9, OverflowLimit - 64'd1, 0, 1'b0);
    send_code(9, OverflowLimit, 0, 1'b0);

    // random: mostly well-formed codes, some cut short, some stray bytes
    while (bytes_sent < StreamBytes) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        len = $urandom_range(1, 9);
        raw = {$urandom, $urandom};
        if (len == 9) begin
          case ($urandom_range(0, 5))
            0:       raw = OverflowLimit + 64'($urandom_range(0, 300));
            1:       raw = OverflowLimit - 64'd1 - 64'($urandom_range(0, 300));
            2:       raw = '1;
            3:       raw = '0;
            default: ;
          endcase
        end
        cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
        send_code(len, raw, cut, $urandom_range(0, 7) == 0);
      end
    end
    byte_valid <= 1'b0;

    // let the checker's count take in the last byte, drain, then settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run fed %0d stream bytes and checked %0d ok, %0d truncated, %0d overflow results",
             bytes_taken, ok_count, trunc_count, over_count);
    $display("Ok code lengths seen, 9 down to 1: %b; output hold-off exercised: %0d",
             lengths_seen[9:1], held);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/pvd_pkg.sv
design/pvd_step.sv
design/prefix_varint_decoder.sv
design/pvd_checker.sv
sim/pvd_checker.sv
sim/tb_top.sv
